@@ src/ial_pkg.sv @@
// Shared command, status and width constants of the indexed array list engine.
`timescale 1ns / 1ps

package ial_pkg;

  localparam int CMD_W   = 3;
  localparam int INDEX_W = 8;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 9;
  localparam int STAT_W  = 2;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] stat_t;

  localparam cmd_t CMD_PUSH   = 3'd0;
  localparam cmd_t CMD_POP    = 3'd1;
  localparam cmd_t CMD_SET    = 3'd2;
  localparam cmd_t CMD_GET    = 3'd3;
  localparam cmd_t CMD_INSERT = 3'd4;
  localparam cmd_t CMD_REMOVE = 3'd5;

  localparam stat_t ST_OK     = 2'd0;
  localparam stat_t ST_FULL   = 2'd1;
  localparam stat_t ST_EMPTY  = 2'd2;
  localparam stat_t ST_BADPOS = 2'd3;

endpackage

@@ src/ial_if.sv @@
// Command and result channel interfaces of the indexed array list engine.
`timescale 1ns / 1ps

interface ial_req_if;
  logic                                valid;
  logic                                ready;
  ial_pkg::cmd_t                       cmd;
  logic [ial_pkg::INDEX_W-1:0]         index;
  logic signed [ial_pkg::WORD_W-1:0]   value;

  modport source (output valid, cmd, index, value, input ready);
  modport sink (input valid, cmd, index, value, output ready);
endinterface

interface ial_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [ial_pkg::WORD_W-1:0]   read_value;
  logic signed [ial_pkg::WORD_W-1:0]   front_value;
  logic signed [ial_pkg::WORD_W-1:0]   back_value;
  logic [ial_pkg::COUNT_W-1:0]         count;
  logic                                is_empty;
  ial_pkg::stat_t                      status;

  modport source (output valid, read_value, front_value, back_value, count, is_empty, status,
                  input ready);
  modport sink (input valid, read_value, front_value, back_value, count, is_empty, status,
                output ready);
endinterface

@@ src/indexed_array_list_engine.sv @@
// Indexed array list engine: ordered word list kept in one synchronous memory.
//
// Usage: commands arrive as beats on req (cmd, index, value); each command
// yields exactly one result beat on rsp (read_value, front_value, back_value,
// count, is_empty, status). One command is worked at a time: req.ready is high
// only while the sequencer is idle.
// After a command is accepted, the sequencer steps through S_FRONT, S_BACK
// and S_DONE; an insert or remove that is not refused first passes through
// S_SHIFT, which moves the entries from index i onward up one place (insert)
// or those after index i down one place (remove). req.ready returns in the
// same cycle that rsp.valid rises. The shift moves one entry per cycle
// through the memory's read and write ports. Front and back are read back
// from the memory after each command.
// The result sits in an output register; a new command is accepted while it
// waits, and a finished result stalls in the sequencer until rsp takes the
// previous beat. Reset (rst, synchronous) empties the list; the memory
// itself is not cleared.
`timescale 1ns / 1ps

module indexed_array_list_engine #(
  parameter int CAPACITY = 256
) (
  input logic      clk,
  input logic      rst,
  ial_req_if.sink  req,
  ial_rsp_if.source rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > ial_pkg::INDEX_W) ? CW : ial_pkg::INDEX_W;
  localparam int WW = ial_pkg::WORD_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_FRONT = 3'd2;
  localparam logic [2:0] S_BACK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [WW-1:0] entries [CAPACITY];
  logic [WW-1:0] rdata;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [WW-1:0] wr_data;

  logic [2:0]      state, state_next;
  logic [CW-1:0]   held, held_next;
  logic [AW-1:0]   ptr, ptr_next;
  logic [CW-1:0]   left, left_next;
  logic            pend, pend_next;
  logic [AW-1:0]   pend_addr, pend_addr_next;
  logic            is_ins, is_ins_next;
  logic [AW-1:0]   op_idx, op_idx_next;
  logic [WW-1:0]   op_val, op_val_next;
  ial_pkg::stat_t  st, st_next;
  logic            get_hit, get_hit_next;
  logic [WW-1:0]   rd_q, rd_q_next;
  logic [WW-1:0]   front_q, front_q_next;
  logic            out_valid, out_valid_next;

  logic signed [WW-1:0]         out_read, out_front, out_back;
  logic [ial_pkg::COUNT_W-1:0]  out_count;
  logic                         out_empty;
  ial_pkg::stat_t               out_status;

  logic          req_acc;
  logic [IW-1:0] idx_w, held_w, clamp_w;
  logic [AW-1:0] clamp;
  logic          empty, full;

  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;

  assign idx_w   = IW'(req.index);
  assign held_w  = IW'(held);
  assign empty   = (held == '0);
  assign full    = (held >= CW'(CAPACITY));
  assign clamp_w = (idx_w >= held_w) ? (held_w - IW'(1)) : idx_w;
  assign clamp   = AW'(clamp_w);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= entries[rd_addr];
    end
  end

  always_comb begin
    state_next     = state;
    held_next      = held;
    ptr_next       = ptr;
    left_next      = left;
    pend_next      = pend;
    pend_addr_next = pend_addr;
    is_ins_next    = is_ins;
    op_idx_next    = op_idx;
    op_val_next    = op_val;
    st_next        = st;
    get_hit_next   = get_hit;
    rd_q_next      = rd_q;
    front_q_next   = front_q;
    out_valid_next = out_valid;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;

    if (rsp.valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (req_acc) begin
          st_next      = ial_pkg::ST_OK;
          get_hit_next = 1'b0;
          rd_q_next    = '0;
          op_val_next  = req.value;
          op_idx_next  = AW'(req.index);
          pend_next    = 1'b0;
          state_next   = S_FRONT;
          case (req.cmd)
            ial_pkg::CMD_PUSH: begin
              if (full) begin
                st_next = ial_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = AW'(held);
                wr_data   = req.value;
                held_next = held + CW'(1);
              end
            end
            ial_pkg::CMD_POP: begin
              if (empty) begin
                st_next = ial_pkg::ST_EMPTY;
              end else begin
                held_next = held - CW'(1);
              end
            end
            ial_pkg::CMD_SET: begin
              if (empty) begin
                st_next = ial_pkg::ST_EMPTY;
              end else begin
                wr_en   = 1'b1;
                wr_addr = clamp;
                wr_data = req.value;
              end
            end
            ial_pkg::CMD_GET: begin
              if (empty) begin
                st_next = ial_pkg::ST_EMPTY;
              end else begin
                rd_en        = 1'b1;
                rd_addr      = clamp;
                get_hit_next = 1'b1;
              end
            end
            ial_pkg::CMD_INSERT: begin
              if (full) begin
                st_next = ial_pkg::ST_FULL;
              end else if (idx_w > held_w) begin
                st_next = ial_pkg::ST_BADPOS;
              end else begin
                is_ins_next = 1'b1;
                ptr_next    = AW'(held_w - IW'(1));
                left_next   = CW'(held_w - idx_w);
                state_next  = S_SHIFT;
              end
            end
            ial_pkg::CMD_REMOVE: begin
              if (empty) begin
                st_next = ial_pkg::ST_EMPTY;
              end else begin
                is_ins_next = 1'b0;
                ptr_next    = AW'(clamp_w + IW'(1));
                left_next   = CW'(held_w - IW'(1) - clamp_w);
                state_next  = S_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr;
          wr_data = rdata;
        end
        if (left != '0) begin
          rd_en          = 1'b1;
          rd_addr        = ptr;
          pend_next      = 1'b1;
          pend_addr_next = is_ins ? (ptr + AW'(1)) : (ptr - AW'(1));
          ptr_next       = is_ins ? (ptr - AW'(1)) : (ptr + AW'(1));
          left_next      = left - CW'(1);
        end else if (pend) begin
          pend_next = 1'b0;
        end else begin
          if (is_ins) begin
            wr_en     = 1'b1;
            wr_addr   = op_idx;
            wr_data   = op_val;
            held_next = held + CW'(1);
          end else begin
            held_next = held - CW'(1);
          end
          state_next = S_FRONT;
        end
      end
      S_FRONT: begin
        if (get_hit) begin
          rd_q_next = rdata;
        end
        rd_en      = (held != '0);
        rd_addr    = '0;
        state_next = S_BACK;
      end
      S_BACK: begin
        front_q_next = rdata;
        rd_en        = (held != '0);
        rd_addr      = AW'(held - CW'(1));
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      pend      <= 1'b0;
      left      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      held      <= held_next;
      pend      <= pend_next;
      left      <= left_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr       <= ptr_next;
    pend_addr <= pend_addr_next;
    is_ins    <= is_ins_next;
    op_idx    <= op_idx_next;
    op_val    <= op_val_next;
    st        <= st_next;
    get_hit   <= get_hit_next;
    rd_q      <= rd_q_next;
    front_q   <= front_q_next;
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      out_read   <= rd_q;
      out_front  <= (held == '0) ? '0 : front_q;
      out_back   <= (held == '0) ? '0 : rdata;
      out_count  <= ial_pkg::COUNT_W'(held);
      out_empty  <= (held == '0);
      out_status <= st;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.read_value  = out_read;
  assign rsp.front_value = out_front;
  assign rsp.back_value  = out_back;
  assign rsp.count       = out_count;
  assign rsp.is_empty    = out_empty;
  assign rsp.status      = out_status;

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(CAPACITY))
    else $error("held count exceeds capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> !req.ready)
    else $error("command accepted while another is in work");

  a_shift_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("shift reads and writes the same entry");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.is_empty) |-> (rsp.front_value == '0 && rsp.back_value == '0
                                     && rsp.count == '0))
    else $error("empty result carries nonzero front, back or count");

  a_full_push_holds: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req.cmd == ial_pkg::CMD_PUSH && full) |=> (held == $past(held)))
    else $error("refused push changed the count");

endmodule

@@ tb/ial_list_checker.sv @@
// Checker of the indexed array list engine: mirrors the list and compares every result beat.
`timescale 1ns / 1ps

module ial_list_checker #(
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic rst,
  ial_req_if   req,
  ial_rsp_if   rsp,
  output int   failures,
  output int   awaiting
);

  typedef struct {
    logic signed [ial_pkg::WORD_W-1:0] read_value;
    logic signed [ial_pkg::WORD_W-1:0] front_value;
    logic signed [ial_pkg::WORD_W-1:0] back_value;
    logic [ial_pkg::COUNT_W-1:0]       count;
    logic                              is_empty;
    ial_pkg::stat_t                    status;
  } list_result_t;

  logic signed [ial_pkg::WORD_W-1:0] list_words [DEPTH];
  int unsigned                       list_len = 0;
  list_result_t                      result_queue [$];
  list_result_t                      oldest;
  int                                fail_total = 0;
  int                                queued = 0;

  assign failures = fail_total;
  assign awaiting = queued;

  function automatic int unsigned bounded_pos(logic [ial_pkg::INDEX_W-1:0] idx);
    return (idx >= list_len) ? list_len - 1 : 32'(idx);
  endfunction

  function automatic list_result_t apply_command(ial_pkg::cmd_t c,
                                                 logic [ial_pkg::INDEX_W-1:0] idx,
                                                 logic signed [ial_pkg::WORD_W-1:0] word);
    list_result_t r;
    int unsigned  pos;
    r.read_value = '0;
    r.status     = ial_pkg::ST_OK;
    case (c)
      ial_pkg::CMD_PUSH: begin
        if (list_len >= DEPTH) begin
          r.status = ial_pkg::ST_FULL;
        end else begin
          list_words[list_len] = word;
          list_len++;
        end
      end
      ial_pkg::CMD_POP: begin
        if (list_len == 0) r.status = ial_pkg::ST_EMPTY;
        else list_len--;
      end
      ial_pkg::CMD_SET: begin
        if (list_len == 0) r.status = ial_pkg::ST_EMPTY;
        else list_words[bounded_pos(idx)] = word;
      end
      ial_pkg::CMD_GET: begin
        if (list_len == 0) r.status = ial_pkg::ST_EMPTY;
        else r.read_value = list_words[bounded_pos(idx)];
      end
      ial_pkg::CMD_INSERT: begin
        if (list_len >= DEPTH) begin
          r.status = ial_pkg::ST_FULL;
        end else if (idx > list_len) begin
          r.status = ial_pkg::ST_BADPOS;
        end else begin
          for (pos = list_len; pos > idx; pos--) list_words[pos] = list_words[pos-1];
          list_words[idx] = word;
          list_len++;
        end
      end
      ial_pkg::CMD_REMOVE: begin
        if (list_len == 0) begin
          r.status = ial_pkg::ST_EMPTY;
        end else begin
          for (pos = bounded_pos(idx); pos + 1 < list_len; pos++)
            list_words[pos] = list_words[pos+1];
          list_len--;
        end
      end
      default: ;
    endcase
    r.is_empty    = (list_len == 0);
    r.front_value = r.is_empty ? '0 : list_words[0];
    r.back_value  = r.is_empty ? '0 : list_words[list_len-1];
    r.count       = list_len[ial_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(string label, logic [ial_pkg::WORD_W-1:0] expv,
                             logic [ial_pkg::WORD_W-1:0] actv);
    if (actv !== expv) begin
      fail_total++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, label, expv, actv);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (result_queue.size() == 0) begin
          fail_total++;
          $display("%0t: result beat with nothing expected, expected none, got count %0d",
                   $time, rsp.count);
        end else begin
          oldest = result_queue.pop_front();
          check_field("read_value", oldest.read_value, rsp.read_value);
          check_field("front_value", oldest.front_value, rsp.front_value);
          check_field("back_value", oldest.back_value, rsp.back_value);
          check_field("count", ial_pkg::WORD_W'(oldest.count), ial_pkg::WORD_W'(rsp.count));
          check_field("is_empty", ial_pkg::WORD_W'(oldest.is_empty),
                      ial_pkg::WORD_W'(rsp.is_empty));
          check_field("status", ial_pkg::WORD_W'(oldest.status),
                      ial_pkg::WORD_W'(rsp.status));
        end
      end
      if (req.valid && req.ready)
        result_queue.push_back(apply_command(req.cmd, req.index, req.value));
    end
    queued <= result_queue.size();
  end

endmodule

@@ tb/tb.sv @@
// Top of the indexed array list engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

  localparam int LIST_DEPTH = 256;
  localparam int DRAIN_CYCLES = LIST_DEPTH + 20;
  localparam int HOLD_CYCLES = 300;
  localparam ial_pkg::cmd_t CMD_RSVD_A = 3'd6;
  localparam ial_pkg::cmd_t CMD_RSVD_B = 3'd7;

  typedef enum int {PH_RECV_SLOW, PH_SEND_SLOW, PH_FULL_RATE} phase_t;

  logic   clk;
  logic   rst;
  int     failures;
  int     awaiting;
  int     shadow_len = 0;
  phase_t phase = PH_RECV_SLOW;

  ial_req_if req ();
  ial_rsp_if rsp ();

  indexed_array_list_engine #(.CAPACITY(LIST_DEPTH)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  ial_list_checker #(.DEPTH(LIST_DEPTH)) i_checker (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .failures (failures),
    .awaiting (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("** indexed_array_list_engine: FAILED **");
    $finish;
  end

  function automatic int idle_pct(phase_t ph, bit sender);
    case (ph)
      PH_RECV_SLOW: return sender ? 33 : 62;
      PH_SEND_SLOW: return sender ? 62 : 33;
      default:      return 0;
    endcase
  endfunction

  function automatic void track_len(ial_pkg::cmd_t c, logic [ial_pkg::INDEX_W-1:0] idx);
    case (c) inside
      ial_pkg::CMD_PUSH:   if (shadow_len < LIST_DEPTH) shadow_len++;
      ial_pkg::CMD_INSERT: if (shadow_len < LIST_DEPTH && idx <= shadow_len) shadow_len++;
      ial_pkg::CMD_POP, ial_pkg::CMD_REMOVE: if (shadow_len > 0) shadow_len--;
      default: ;
    endcase
  endfunction

  function automatic logic signed [ial_pkg::WORD_W-1:0] pick_word();
    if ($urandom_range(9) != 0) return $urandom;
    case ($urandom_range(3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      default: return -1;
    endcase
  endfunction

  function automatic logic [ial_pkg::INDEX_W-1:0] pick_index();
    if (shadow_len == 0 || $urandom_range(4) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(shadow_len > 255 ? 255 : shadow_len));
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_item(ial_pkg::cmd_t c, logic [ial_pkg::INDEX_W-1:0] idx,
                           logic signed [ial_pkg::WORD_W-1:0] word);
    while ($urandom_range(99) < idle_pct(phase, 1'b1)) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.cmd   <= c;
    req.index <= idx;
    req.value <= word;
    do @(posedge clk); while (!req.ready);
    track_len(c, idx);
    @(negedge clk);
  endtask

  task automatic send_random(int grow_pct);
    ial_pkg::cmd_t c;
    int            roll;
    roll = $urandom_range(99);
    if (roll < 4) c = roll[0] ? CMD_RSVD_A : CMD_RSVD_B;
    else if (roll < 4 + grow_pct) c = $urandom_range(1) ? ial_pkg::CMD_PUSH : ial_pkg::CMD_INSERT;
    else if (roll < 19 + grow_pct) c = ial_pkg::CMD_SET;
    else if (roll < 34 + grow_pct) c = ial_pkg::CMD_GET;
    else c = $urandom_range(1) ? ial_pkg::CMD_POP : ial_pkg::CMD_REMOVE;
    send_item(c, pick_index(), pick_word());
  endtask

  task automatic wait_all_results();
    req.valid <= 1'b0;
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
  endtask

  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && phase == PH_FULL_RATE) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= idle_pct(phase, 1'b0));
      end
    end
  end

  initial begin
    rst       = 1'b1;
    req.valid = 1'b0;
    req.cmd   = ial_pkg::CMD_PUSH;
    req.index = '0;
    req.value = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(ial_pkg::CMD_POP, 8'd0, 32'sd7);
    send_item(ial_pkg::CMD_SET, 8'd0, 32'sd11);
    send_item(ial_pkg::CMD_GET, 8'd255, '0);
    send_item(ial_pkg::CMD_REMOVE, 8'd255, '0);
    send_item(ial_pkg::CMD_INSERT, 8'd1, 32'sd3);
    send_item(ial_pkg::CMD_INSERT, 8'd0, 32'sh7fff_ffff);
    send_item(ial_pkg::CMD_PUSH, 8'd0, 32'sh8000_0000);
    send_item(ial_pkg::CMD_PUSH, 8'd255, '0);
    send_item(ial_pkg::CMD_PUSH, 8'd0, -1);
    send_item(ial_pkg::CMD_INSERT, 8'd4, 32'sd5);
    send_item(ial_pkg::CMD_INSERT, 8'd200, 32'sd9);
    send_item(ial_pkg::CMD_INSERT, 8'd1, 32'sh5555_5555);
    send_item(ial_pkg::CMD_GET, 8'd255, '0);
    send_item(ial_pkg::CMD_GET, 8'd0, '0);
    send_item(ial_pkg::CMD_SET, 8'd255, 32'shaaaa_aaaa);
    send_item(ial_pkg::CMD_SET, 8'd2, 32'sd1);
    send_item(ial_pkg::CMD_REMOVE, 8'd255, '0);
    send_item(ial_pkg::CMD_REMOVE, 8'd0, '0);
    send_item(CMD_RSVD_A, 8'd0, '0);
    send_item(CMD_RSVD_B, 8'd255, -1);
    send_item(ial_pkg::CMD_GET, 8'd1, '0);
    send_item(ial_pkg::CMD_POP, 8'd0, '0);
    send_item(ial_pkg::CMD_REMOVE, 8'd1, '0);

    repeat (150) send_random(45);

    wait_all_results();
    phase <= PH_SEND_SLOW;
    @(negedge clk);
    while (shadow_len < LIST_DEPTH) begin
      if ($urandom_range(9) == 0)
        send_item(ial_pkg::CMD_INSERT, 8'(shadow_len + 1), pick_word());
      else if ($urandom_range(1)) send_item(ial_pkg::CMD_PUSH, pick_index(), pick_word());
      else send_item(ial_pkg::CMD_INSERT, 8'($urandom_range(shadow_len)), pick_word());
    end
    send_item(ial_pkg::CMD_PUSH, 8'd0, pick_word());
    send_item(ial_pkg::CMD_INSERT, 8'd0, pick_word());
    send_item(ial_pkg::CMD_GET, 8'd255, '0);
    send_item(ial_pkg::CMD_SET, 8'd128, pick_word());
    send_item(ial_pkg::CMD_REMOVE, 8'd255, '0);
    send_item(ial_pkg::CMD_INSERT, 8'd255, pick_word());
    send_item(ial_pkg::CMD_INSERT, 8'd255, pick_word());
    send_item(ial_pkg::CMD_GET, 8'd0, '0);

    phase <= PH_FULL_RATE;
    repeat (100) send_random(20);
    while (shadow_len > 0)
      send_item($urandom_range(1) ? ial_pkg::CMD_POP : ial_pkg::CMD_REMOVE, pick_index(),
                pick_word());
    send_item(ial_pkg::CMD_GET, 8'd17, '0);
    send_item(ial_pkg::CMD_INSERT, 8'd3, pick_word());
    send_item(ial_pkg::CMD_INSERT, 8'd0, pick_word());
    send_item(ial_pkg::CMD_POP, 8'd0, '0);

    wait_all_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0 && awaiting == 0) begin
      $display("** indexed_array_list_engine: PASSED **");
    end else begin
      if (awaiting != 0) $display("%0t: %0d expected results never arrived", $time, awaiting);
      $display("** indexed_array_list_engine: FAILED **");
    end
    $finish;
  end

endmodule
